/* hw/rtl/drd_pkg.sv */
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and constants for the detection row decoder.
// ----------------------------------------------------------------------------
package drd_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_OBJECTNESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 2'd2;

  localparam logic [12:0] IMAGE_SIZE_RST      = 13'd640;
  localparam logic [16:0] SCORE_THRESHOLD_RST = 17'd16384;

  // 2.0 in Q16.16: boxes at or below this are normalized.
  localparam logic signed [31:0] NORM_LIMIT = 32'sd131072;

  typedef struct packed {
    logic signed [31:0] element_value;
    logic               row_last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic signed [15:0] box_width;
    logic signed [15:0] box_height;
    logic signed [31:0] det_score;
    logic signed [7:0]  det_class;
  } out_item_t;

  // A finished row as captured at its last element, with the settings in use.
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] box_w;
    logic signed [31:0] box_h;
    logic signed [31:0] objectness;
    logic signed [31:0] best_score;
    logic signed [7:0]  best_class;
    logic               has_obj;
    logic [12:0]        image_size;
    logic [16:0]        score_thr;
  } row_snap_t;

  // Scaled box values and the raw score product (Q32.32).
  typedef struct packed {
    logic signed [45:0] x_s;
    logic signed [45:0] y_s;
    logic signed [45:0] w_s;
    logic signed [45:0] h_s;
    logic signed [63:0] score_prod;
    logic signed [7:0]  best_class;
    logic [16:0]        score_thr;
  } prod_t;

endpackage

/* hw/rtl/drd_row_accum.sv */
// ----------------------------------------------------------------------------
// drd_row_accum
// Collects the elements of one row and hands a snapshot on at row end.
// ----------------------------------------------------------------------------
module drd_row_accum #(
  parameter int MAX_CLASSES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  drd_pkg::in_item_t in_data,
  input  logic              has_obj,
  input  logic [12:0]       image_size,
  input  logic [16:0]       score_thr,
  output logic              snap_valid,
  output drd_pkg::row_snap_t snap
);
  import drd_pkg::*;

  // Position must reach the first place past the last class element.
  localparam int POS_W = $clog2(MAX_CLASSES + 6);

  logic                   acc;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       cls_first;
  logic [POS_W-1:0]       cls_end;
  logic [POS_W-1:0]       cls_idx;
  logic                   in_class;
  logic                   had_class;
  logic                   better;
  logic signed [31:0]     v;
  logic signed [31:0]     cx_r, cy_r, bw_r, bh_r, obj_r, best_r;
  logic signed [31:0]     cx_nxt, cy_nxt, bw_nxt, bh_nxt, obj_nxt, best_nxt;
  logic signed [7:0]      cls_r, cls_nxt;
  logic                   snap_valid_r, snap_valid_nxt;
  row_snap_t              snap_r, snap_nxt;

  assign acc       = in_valid && en;
  assign v         = in_data.element_value;
  assign cls_first = has_obj ? POS_W'(5) : POS_W'(4);
  assign cls_end   = cls_first + POS_W'(MAX_CLASSES);
  assign cls_idx   = pos_r - cls_first;
  assign had_class = pos_r >= cls_first;
  assign in_class  = had_class && (pos_r < cls_end);
  assign better    = in_class && (v > best_r);

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    bw_nxt   = bw_r;
    bh_nxt   = bh_r;
    obj_nxt  = obj_r;
    best_nxt = better ? v : best_r;
    cls_nxt  = better ? 8'(cls_idx) : cls_r;
    pos_nxt  = (pos_r < cls_end) ? pos_r + POS_W'(1) : pos_r;
    if (pos_r == POS_W'(0)) cx_nxt = v;
    if (pos_r == POS_W'(1)) cy_nxt = v;
    if (pos_r == POS_W'(2)) bw_nxt = v;
    if (pos_r == POS_W'(3)) bh_nxt = v;
    if (pos_r == POS_W'(4) && has_obj) obj_nxt = v;

    snap_nxt.center_x   = cx_nxt;
    snap_nxt.center_y   = cy_nxt;
    snap_nxt.box_w      = bw_nxt;
    snap_nxt.box_h      = bh_nxt;
    snap_nxt.objectness = obj_nxt;
    snap_nxt.best_score = best_nxt;
    snap_nxt.best_class = cls_nxt;
    snap_nxt.has_obj    = has_obj;
    snap_nxt.image_size = image_size;
    snap_nxt.score_thr  = score_thr;

    snap_valid_nxt = acc && in_data.row_last && had_class;

    // Every row end clears the row, whether or not it emits.
    if (in_data.row_last) begin
      pos_nxt  = '0;
      cx_nxt   = '0;
      cy_nxt   = '0;
      bw_nxt   = '0;
      bh_nxt   = '0;
      obj_nxt  = '0;
      best_nxt = '0;
      cls_nxt  = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      cx_r         <= '0;
      cy_r         <= '0;
      bw_r         <= '0;
      bh_r         <= '0;
      obj_r        <= '0;
      best_r       <= '0;
      cls_r        <= '1;
      snap_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        pos_r  <= pos_nxt;
        cx_r   <= cx_nxt;
        cy_r   <= cy_nxt;
        bw_r   <= bw_nxt;
        bh_r   <= bh_nxt;
        obj_r  <= obj_nxt;
        best_r <= best_nxt;
        cls_r  <= cls_nxt;
      end
      if (en) begin
        snap_valid_r <= snap_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  // The running best only ever moves to a strictly positive score.
  a_best_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    best_r >= 0)
    else $error("best score went negative");

  a_no_best_no_class: assert property (@(posedge clk) disable iff (!rst_n)
    (best_r == 0) |-> (cls_r == -8'sd1))
    else $error("class set without a positive score");

  a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.row_last) |=> (pos_r == '0 && best_r == 0))
    else $error("row state not cleared at row end");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_CLASSES + 5))
    else $error("element position past its limit");

endmodule

/* hw/rtl/drd_mult_stage.sv */
// ----------------------------------------------------------------------------
// drd_mult_stage
// Scales normalized boxes by the image size and forms the score product.
// ----------------------------------------------------------------------------
module drd_mult_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               snap_valid,
  input  drd_pkg::row_snap_t snap,
  output logic               prod_valid,
  output drd_pkg::prod_t     prod
);
  import drd_pkg::*;

  logic               norm;
  logic signed [13:0] scale;
  logic               prod_valid_r;
  prod_t              prod_r, prod_nxt;

  assign norm  = (snap.center_x <= NORM_LIMIT) && (snap.center_y <= NORM_LIMIT) &&
                 (snap.box_w <= NORM_LIMIT) && (snap.box_h <= NORM_LIMIT);
  assign scale = $signed({1'b0, snap.image_size});

  always_comb begin
    if (norm) begin
      prod_nxt.x_s = 46'(snap.center_x) * 46'(scale);
      prod_nxt.y_s = 46'(snap.center_y) * 46'(scale);
      prod_nxt.w_s = 46'(snap.box_w) * 46'(scale);
      prod_nxt.h_s = 46'(snap.box_h) * 46'(scale);
    end else begin
      prod_nxt.x_s = 46'(snap.center_x);
      prod_nxt.y_s = 46'(snap.center_y);
      prod_nxt.w_s = 46'(snap.box_w);
      prod_nxt.h_s = 46'(snap.box_h);
    end
    // Without objectness the best score is placed in the same Q32.32 form,
    // so the next stage treats both cases alike.
    if (snap.has_obj) begin
      prod_nxt.score_prod = 64'(snap.objectness) * 64'(snap.best_score);
    end else begin
      prod_nxt.score_prod = {{16{snap.best_score[31]}}, snap.best_score, 16'b0};
    end
    prod_nxt.best_class = snap.best_class;
    prod_nxt.score_thr  = snap.score_thr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (en) begin
      prod_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_valid = prod_valid_r;
  assign prod       = prod_r;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(prod_valid_r))
    else $error("product stage moved while stalled");

  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (en && snap_valid) |=> prod_valid_r)
    else $error("row snapshot lost in product stage");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !snap_valid) |=> !prod_valid_r)
    else $error("product stage invented an item");

endmodule

/* hw/rtl/drd_emit_stage.sv */
// ----------------------------------------------------------------------------
// drd_emit_stage
// Forms edges and score, tests the threshold, rounds and saturates.
// ----------------------------------------------------------------------------
module drd_emit_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                prod_valid,
  input  drd_pkg::prod_t      prod,
  output logic                out_valid,
  output drd_pkg::out_item_t  out_det
);
  import drd_pkg::*;

  typedef struct packed {
    logic signed [47:0] left2;
    logic signed [47:0] top2;
    logic signed [47:0] w;
    logic signed [47:0] h;
    logic signed [31:0] score;
    logic signed [7:0]  best_class;
    logic               pass;
  } edge_t;

  // Divide by 2^17 rounding half away from zero, then clamp to 16 bits.
  function automatic logic signed [15:0] round_sat17(input logic signed [47:0] v);
    logic signed [47:0] b;
    logic signed [47:0] q;
    b = v + $signed({31'b0, ~v[47], {16{v[47]}}});
    q = b >>> 17;
    if (q > 48'sd32767) begin
      return 16'sh7FFF;
    end else if (q < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  function automatic logic signed [15:0] round_sat16(input logic signed [47:0] v);
    logic signed [47:0] b;
    logic signed [47:0] q;
    b = v + $signed({32'b0, ~v[47], {15{v[47]}}});
    q = b >>> 16;
    if (q > 48'sd32767) begin
      return 16'sh7FFF;
    end else if (q < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  logic signed [63:0] biased;
  logic signed [47:0] score48;
  logic signed [31:0] score32;
  logic               e_valid_r;
  edge_t              e_r, e_nxt;
  logic               out_valid_r;
  out_item_t          out_r, out_nxt;

  // Truncate the Q32.32 product toward zero to Q16.16, then saturate.
  assign biased  = prod.score_prod + $signed({48'b0, {16{prod.score_prod[63]}}});
  assign score48 = biased[63:16];

  always_comb begin
    if (score48 > 48'sd2147483647) begin
      score32 = 32'sh7FFFFFFF;
    end else if (score48 < -48'sd2147483648) begin
      score32 = 32'sh80000000;
    end else begin
      score32 = score48[31:0];
    end
    e_nxt.left2      = 48'(prod.x_s) + 48'(prod.x_s) - 48'(prod.w_s);
    e_nxt.top2       = 48'(prod.y_s) + 48'(prod.y_s) - 48'(prod.h_s);
    e_nxt.w          = 48'(prod.w_s);
    e_nxt.h          = 48'(prod.h_s);
    e_nxt.score      = score32;
    e_nxt.best_class = prod.best_class;
    e_nxt.pass       = score32 >= $signed({15'b0, prod.score_thr});
  end

  always_comb begin
    out_nxt.box_left   = round_sat17(e_r.left2);
    out_nxt.box_top    = round_sat17(e_r.top2);
    out_nxt.box_width  = round_sat16(e_r.w);
    out_nxt.box_height = round_sat16(e_r.h);
    out_nxt.det_score  = e_r.score;
    out_nxt.det_class  = e_r.best_class;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r   <= prod_valid;
      out_valid_r <= e_valid_r && e_r.pass;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r   <= e_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_det   = out_r;

  // The threshold is never negative, so nothing below zero can be emitted.
  a_emit_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.det_score >= 0))
    else $error("emitted a negative score");

  a_emit_needs_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !(e_valid_r && e_r.pass)) |=> !out_valid_r)
    else $error("emitted a row that failed the threshold");

  a_edge_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(e_valid_r))
    else $error("edge stage moved while stalled");

endmodule

/* hw/rtl/detection_row_decode.sv */
// ----------------------------------------------------------------------------
// detection_row_decode
// Decodes streamed detector output rows into at most one box detection per row.
// ----------------------------------------------------------------------------
// Usage: in_data carries one Q16.16 element of a row per item, in the order
// center x, center y, width, height, objectness (only when has_objectness is
// set) and then the class scores; row_last marks the final element. The
// block takes one element per clock cycle while in_stall is low. A row that
// has at least one class element and whose score reaches the threshold
// yields one item on out_det, marked by out_valid once the row has passed
// the snapshot, product, edge and output registers; other rows yield
// nothing. The pipeline is the row collector, a product register (box
// scaling and the objectness product), an edge and score register and the
// output register, so a row end can follow on the very next cycle.
// When the receiver raises out_stall while a result waits, the whole
// pipeline holds and in_stall is raised in the same cycle; with out_stall
// low the block never stalls its input. Configuration writes on the cfg_
// port are always taken (cfg_ready is high); each row end captures the
// settings it uses. Reset clears the row state, empties the pipeline and
// loads the register defaults: no objectness, image size 640 and threshold
// 0.25.
// ----------------------------------------------------------------------------
module detection_row_decode #(
  parameter int MAX_CLASSES = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  drd_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output drd_pkg::out_item_t             out_det,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [drd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import drd_pkg::*;

  logic        en;
  logic        has_obj_r;
  logic [12:0] image_size_r;
  logic [16:0] score_thr_r;
  logic        snap_valid;
  row_snap_t   snap;
  logic        prod_valid;
  prod_t       prod;

  // The whole pipeline advances unless a finished result is being held.
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_obj_r    <= 1'b0;
      image_size_r <= IMAGE_SIZE_RST;
      score_thr_r  <= SCORE_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HAS_OBJECTNESS:  has_obj_r    <= cfg_wdata[0];
        CFG_IMAGE_SIZE:      image_size_r <= cfg_wdata[12:0];
        CFG_SCORE_THRESHOLD: score_thr_r  <= cfg_wdata[16:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  drd_row_accum #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_row_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .has_obj    (has_obj_r),
    .image_size (image_size_r),
    .score_thr  (score_thr_r),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  drd_mult_stage u_mult_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .snap_valid (snap_valid),
    .snap       (snap),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  drd_emit_stage u_emit_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .prod_valid (prod_valid),
    .prod       (prod),
    .out_valid  (out_valid),
    .out_det    (out_det)
  );

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no held result");

  a_image_size_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index == CFG_IMAGE_SIZE) |=> (image_size_r == $past(cfg_wdata[12:0])))
    else $error("image size write lost");

  a_held_result_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_det)))
    else $error("held result changed");

endmodule

/* tb/sv/drd_checker.sv */
// ----------------------------------------------------------------------------
// drd_checker
// Watches the element, result and register channels of the row decoder,
// predicts each detection and compares it field by field.
// ----------------------------------------------------------------------------
module drd_checker #(
  parameter int MAX_CLASSES = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  drd_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  drd_pkg::out_item_t            out_det,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [drd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  output int                            fail_count,
  output int                            dets_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies.
  bit     obj_enabled;
  int     scale_px;
  int     min_score;

  // Row being collected.
  int     pos;
  longint cx, cy, bw, bh, obj, best;
  int     best_cls;

  drd_pkg::out_item_t pending_dets[$];
  int     errors;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Divide by 2^sh, halves go away from zero.
  function automatic longint round_away(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -m : m;
  endfunction

  task automatic clear_row();
    pos      = 0;
    cx       = 0;
    cy       = 0;
    bw       = 0;
    bh       = 0;
    obj      = 0;
    best     = 0;
    best_cls = -1;
  endtask

  task automatic decode_element(input drd_pkg::in_item_t item);
    longint             v, x, y, w, h, score, mag;
    int                 first_cls;
    bit                 had_class;
    drd_pkg::out_item_t det;
    v = longint'(item.element_value);
    first_cls = obj_enabled ? 5 : 4;
    if (pos == 0) cx = v;
    else if (pos == 1) cy = v;
    else if (pos == 2) bw = v;
    else if (pos == 3) bh = v;
    else if (pos == 4 && obj_enabled) obj = v;
    else if (pos >= first_cls && pos - first_cls < MAX_CLASSES) begin
      if (v > best) begin
        best     = v;
        best_cls = pos - first_cls;
      end
    end
    had_class = (pos >= first_cls);
    if (pos < first_cls + MAX_CLASSES) pos++;
    if (item.row_last) begin
      if (had_class) begin
        x = cx;
        y = cy;
        w = bw;
        h = bh;
        if (x <= 131072 && y <= 131072 && w <= 131072 && h <= 131072) begin
          x = x * scale_px;
          y = y * scale_px;
          w = w * scale_px;
          h = h * scale_px;
        end
        if (obj_enabled) begin
          score = obj * best;
          mag   = ((score < 0) ? -score : score) >> 16;
          score = (score < 0) ? -mag : mag;
        end else begin
          score = best;
        end
        score = clamp(score, -64'sd2147483648, 64'sd2147483647);
        if (score >= longint'(min_score)) begin
          det.box_left   = 16'(clamp(round_away(2 * x - w, 17), -32768, 32767));
          det.box_top    = 16'(clamp(round_away(2 * y - h, 17), -32768, 32767));
          det.box_width  = 16'(clamp(round_away(w, 16), -32768, 32767));
          det.box_height = 16'(clamp(round_away(h, 16), -32768, 32767));
          det.det_score  = 32'(score);
          det.det_class  = 8'(best_cls);
          pending_dets   = {pending_dets, det};
        end
      end
      clear_row();
    end
  endtask

  always @(posedge clk) begin : monitor
    drd_pkg::out_item_t want;
    bit                 bad;
    if (!rst_n) begin
      obj_enabled = 1'b0;
      scale_px    = 640;
      min_score   = 16384;
      clear_row();
      pending_dets.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          drd_pkg::CFG_HAS_OBJECTNESS:  obj_enabled = cfg_wdata[0];
          drd_pkg::CFG_IMAGE_SIZE:      scale_px    = int'(cfg_wdata[12:0]);
          drd_pkg::CFG_SCORE_THRESHOLD: min_score   = int'(cfg_wdata[16:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_element(in_data);
      if (out_valid && !out_stall) begin
        if (pending_dets.size() == 0) begin
          if (errors < 10)
            $display("%t: detection with none expected: L%0d T%0d W%0d H%0d S%0d C%0d",
                     $realtime, out_det.box_left, out_det.box_top, out_det.box_width,
                     out_det.box_height, out_det.det_score, out_det.det_class);
          errors++;
        end else begin
          want = pending_dets.pop_front();
          bad = (out_det.box_left !== want.box_left) ||
                (out_det.box_top !== want.box_top) ||
                (out_det.box_width !== want.box_width) ||
                (out_det.box_height !== want.box_height) ||
                (out_det.det_score !== want.det_score) ||
                (out_det.det_class !== want.det_class);
          if (bad) begin
            if (errors < 10) begin
              $display("%t: detection mismatch", $realtime);
              $display("  expected L%0d T%0d W%0d H%0d S%0d C%0d", want.box_left,
                       want.box_top, want.box_width, want.box_height, want.det_score,
                       want.det_class);
              $display("  actual   L%0d T%0d W%0d H%0d S%0d C%0d", out_det.box_left,
                       out_det.box_top, out_det.box_width, out_det.box_height,
                       out_det.det_score, out_det.det_class);
            end
            errors++;
          end
        end
      end
    end
    fail_count   <= errors;
    dets_pending <= pending_dets.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives detector rows into the row decoder under random idling on both
// channels, reprograms the registers between phases and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CLASSES  = 128;
  // A result leaves through the snapshot, product, edge and output registers
  // after the row end; the drain also covers rows that end without a detection.
  localparam int DRAIN_CYCLES = 8;
  // Length of the long receiver hold-off that backs the pipeline up.
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 300;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  drd_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  drd_pkg::out_item_t            out_det;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [drd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_wdata = '0;

  int fail_count;
  int dets_pending;

  // Stimulus bookkeeping. cur_obj mirrors the objectness setting so that
  // rows can be shaped to the layout the block currently expects.
  int total_items = 0;
  bit cur_obj     = 1'b0;
  // While no_idle is set, neither side inserts any wait cycles.
  bit no_idle     = 1'b0;
  // The stimulus raises hold_req; the receiver answers with one long stall.
  int hold_req    = 0;
  int hold_done   = 0;

  detection_row_decode #(
    .MAX_CLASSES(MAX_CLASSES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_det  (out_det),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  drd_checker #(
    .MAX_CLASSES(MAX_CLASSES)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_det     (out_det),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .dets_pending(dets_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Offer one element and return right after the edge that takes it. The
  // valid stays high so that back-to-back items need no extra assignment.
  task automatic send_item(input logic [31:0] value, input logic is_last);
    drd_pkg::in_item_t item;
    int                gap;
    item.element_value = value;
    item.row_last      = is_last;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    total_items++;
  endtask

  // Stop offering items and wait until every predicted detection has come
  // out, then give the pipeline time to finish rows that produce nothing.
  // The first edge lets the checker's pending count catch up.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (dets_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic cfg_write(input logic [drd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input bit obj, input int size, input int thr);
    wait_idle();
    cfg_write(drd_pkg::CFG_HAS_OBJECTNESS, 32'(obj));
    cfg_write(drd_pkg::CFG_IMAGE_SIZE, 32'(size));
    cfg_write(drd_pkg::CFG_SCORE_THRESHOLD, 32'(thr));
    cfg_valid <= 1'b0;
    cur_obj = obj;
  endtask

  // Box values: mostly normalized, some around the 2.0 boundary, some in
  // pixels, some negative and some anywhere in the 32-bit range.
  function automatic logic [31:0] pick_box();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 32'($urandom_range(0, 131072));
      6:                return 32'($urandom_range(131071, 131073));
      7:                return ($urandom_range(0, 1000) << 16) | $urandom_range(0, 65535);
      8:                return $urandom;
      default:          return -32'($urandom_range(0, 131072));
    endcase
  endfunction

  function automatic logic [31:0] pick_score();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return 32'($urandom_range(0, 65536));
      7:                   return -32'($urandom_range(1, 65536));
      8:                   return $urandom;
      default:             return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] pick_obj();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return 32'($urandom_range(0, 65536));
      7:                   return $urandom;
      8:                   return -32'($urandom_range(1, 65536));
      default:             return 32'd65536;
    endcase
  endfunction

  // One random row. Most rows are complete with a handful of classes. A few
  // run past the class limit with the largest values in the ignored tail, a
  // few end before any class element, and a few never mark their end so
  // that they run into the next row.
  task automatic send_random_row();
    logic [31:0] vals[$];
    int          first_cls, roll, n_cls, len;
    bit          drop_last;
    first_cls = cur_obj ? 5 : 4;
    roll = $urandom_range(0, 199);
    n_cls = (roll < 3) ? $urandom_range(MAX_CLASSES, MAX_CLASSES + 8)
                       : $urandom_range(1, 6);
    repeat (4) vals = {vals, pick_box()};
    if (cur_obj) vals = {vals, pick_obj()};
    repeat (n_cls) vals = {vals, pick_score()};
    if (roll < 3) begin
      vals[first_cls + MAX_CLASSES - 1] = 32'h7FFF_FFF0;
      if (n_cls > MAX_CLASSES) vals[first_cls + MAX_CLASSES] = 32'h7FFF_FFFF;
    end
    len = vals.size();
    if (roll >= 3 && roll < 20) len = $urandom_range(1, first_cls);
    drop_last = (roll >= 20 && roll < 26);
    no_idle = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < len; i++)
      send_item(vals[i], (i == len - 1) && !drop_last);
  endtask

  // Receiver: stalls a random number of cycles before taking each result,
  // and once per request holds off for a long stretch while the sender
  // keeps going, so the pipeline fills and stalls the input.
  initial begin : receiver
    int n;
    forever begin
      if (hold_req != hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 3);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase_end;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no objectness, 640 px, threshold 0.25. A normalized
    // box whose second class wins.
    send_item(32'd65536, 1'b0);
    send_item(32'd32768, 1'b0);
    send_item(32'd16384, 1'b0);
    send_item(32'd8192, 1'b0);
    send_item(32'd32768, 1'b0);
    send_item(32'd49152, 1'b1);

    // A row that ends before any class element produces nothing, and its
    // box values must not leak into the next row.
    send_item(32'd65536, 1'b0);
    send_item(32'd65536, 1'b1);

    // Unit scale and zero threshold: half-pixel sizes round away from zero,
    // and a row with no positive class emits class -1 with score zero.
    set_config(1'b0, 1, 0);
    send_item(32'h0000_8000, 1'b0);
    send_item(32'hFFFF_8000, 1'b0);
    send_item(32'h0000_8000, 1'b0);
    send_item(32'hFFFF_8000, 1'b0);
    send_item(32'hFFFF_0000, 1'b0);
    send_item(32'h0000_0000, 1'b1);

    // Extreme box values: not normalized, every edge saturates.
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);

    // Largest scale with objectness: the score product saturates.
    set_config(1'b1, 4096, 0);
    send_item(32'd65536, 1'b0);
    send_item(32'd65536, 1'b0);
    send_item(32'd65536, 1'b0);
    send_item(32'd65536, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);

    // Negative objectness gives a negative score, which falls below even a
    // zero threshold.
    send_item(32'd0, 1'b0);
    send_item(32'd0, 1'b0);
    send_item(32'd0, 1'b0);
    send_item(32'd0, 1'b0);
    send_item(32'hFFFF_0000, 1'b0);
    send_item(32'd32768, 1'b1);

    // Objectness switched on in the middle of a row: the fifth element is
    // then taken as objectness.
    set_config(1'b0, 640, 16384);
    send_item(32'd40000, 1'b0);
    send_item(32'd50000, 1'b0);
    send_item(32'd20000, 1'b0);
    send_item(32'd30000, 1'b0);
    wait_idle();
    cfg_write(drd_pkg::CFG_HAS_OBJECTNESS, 32'd1);
    cfg_valid <= 1'b0;
    cur_obj = 1'b1;
    send_item(32'd65536, 1'b0);
    send_item(32'd65536, 1'b1);

    // Random phases, the first few at the register extremes. Two of them
    // start with a long receiver hold-off.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       set_config(1'b0, 640, 16384);
        1:       set_config(1'b1, 4096, 0);
        2:       set_config(1'b0, 1, 65536);
        3:       set_config(1'b1, 1, 65536);
        4:       set_config(1'b0, 4096, 0);
        default: set_config(1'($urandom_range(0, 1)), $urandom_range(1, 4096),
                            $urandom_range(0, 65536));
      endcase
      if (p == 1 || p == 4) hold_req++;
      phase_end = total_items + PHASE_ITEMS;
      while (total_items < phase_end) send_random_row();
    end

    no_idle = 1'b0;
    wait_idle();
    if (fail_count == 0 && dets_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
